// ===== rtl/psds_pkg.sv =====
// Package: shared constants, state type and inter-cell structs for the pairwise sum sorter.
package psds_pkg;

  localparam int MAX_ITEMS = 16;
  localparam int IN_W      = 16;
  localparam int SUM_W     = IN_W + 1;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_t;

  // broadcast control to every cell
  typedef struct packed {
    logic ins;    // insert the broadcast sum this cycle
    logic shift;  // move every entry one cell toward the head
  } cell_ctrl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic             valid;
    logic             less;   // empty or holds a value below the broadcast sum
    logic [SUM_W-1:0] value;
  } link_t;

endpackage

// ===== rtl/psds_cell.sv =====
// Sorting cell: holds one sum; inserts in order or shifts toward the head.
module psds_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  psds_pkg::cell_ctrl_t          ctrl,
  input  logic [psds_pkg::SUM_W-1:0]    ins_value,
  input  psds_pkg::link_t               left,
  input  psds_pkg::link_t               right,
  output psds_pkg::link_t               self
);

  logic                       valid_r, valid_nxt;
  logic [psds_pkg::SUM_W-1:0] value_r, value_nxt;
  logic                       less;

  assign less = !valid_r || ($signed(value_r) < $signed(ins_value));

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (ctrl.shift) begin
      valid_nxt = right.valid;
      value_nxt = right.value;
    end else if (ctrl.ins && less) begin
      // left neighbor also moves down: take its entry, else this is the slot
      valid_nxt = left.less ? left.valid : 1'b1;
      value_nxt = left.less ? left.value : ins_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign self.valid = valid_r;
  assign self.less  = less;
  assign self.value = value_r;

endmodule

// ===== rtl/pairwise_sum_sort_descending_unit.sv =====
// Top level: pairwise sum collector with an insertion sorting chain, descending output.
//
// Usage
//   Input channel: an item (in_first_value, in_second_value, in_is_last) is taken
//   at a rising edge with start high and busy low. Each item's 17-bit sum goes
//   straight into a chain of MAX_ITEMS cells that keeps the set sorted, largest
//   at the head, so the chain takes one beat per cycle while a set fills.
//   Items that arrive once the chain is full are dropped; a dropped item
//   marked last still closes the set.
//   After the item marked last, busy goes high until every stored sum is out,
//   the chain shifts its head out once per cycle, and results appear on
//   out_sorted_sum / out_last_out with out_valid high for one cycle each, the
//   first one registered from the head cell once the drain begins, then back to back.
//   out_last_out marks the smallest, final sum of the set.
//   No item of a new set is taken while busy is high, so the drain through the
//   head cell limits how fast sets can follow one another.
//   The receiver cannot stall: each result is there for exactly one cycle.
//   A new set may start in the cycle the final result is shown.
//   Reset (rst_n low, synchronous) empties the chain and the fill count and
//   drops any pending results.
module pairwise_sum_sort_descending_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [psds_pkg::IN_W-1:0]  in_first_value,
  input  logic signed [psds_pkg::IN_W-1:0]  in_second_value,
  input  logic                              in_is_last,
  output logic                              out_valid,
  output logic signed [psds_pkg::SUM_W-1:0] out_sorted_sum,
  output logic                              out_last_out
);

  localparam int N = psds_pkg::MAX_ITEMS;

  psds_pkg::state_t           state_r, state_nxt;
  logic [psds_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_last_r, out_last_nxt;
  logic [psds_pkg::SUM_W-1:0] out_sum_r, out_sum_nxt;

  logic                       accept;
  logic                       full;
  logic [psds_pkg::SUM_W-1:0] ins_sum;
  psds_pkg::cell_ctrl_t       ctrl;
  psds_pkg::link_t            links [N];
  logic [N-1:0]               valid_vec;

  assign accept = start && !busy;
  assign full   = (cnt_r == psds_pkg::CNT_W'(N));

  // 17-bit sum of two sign-extended 16-bit values never overflows
  assign ins_sum = psds_pkg::SUM_W'({in_first_value[psds_pkg::IN_W-1], in_first_value})
                 + psds_pkg::SUM_W'({in_second_value[psds_pkg::IN_W-1], in_second_value});

  // ---------------- sorting chain ----------------
  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      psds_pkg::link_t left_l;
      psds_pkg::link_t right_l;

      if (gi == 0) begin : g_head
        // nothing above the head: it never takes a neighbor's entry on insert
        assign left_l = '{valid: 1'b1, less: 1'b0, value: '0};
      end else begin : g_mid
        assign left_l = links[gi-1];
      end

      if (gi == N - 1) begin : g_tail
        // tail fills with an empty slot when the chain shifts
        assign right_l = '{valid: 1'b0, less: 1'b1, value: '0};
      end else begin : g_body
        assign right_l = links[gi+1];
      end

      psds_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .ins_value (ins_sum),
        .left      (left_l),
        .right     (right_l),
        .self      (links[gi])
      );

      assign valid_vec[gi] = links[gi].valid;
    end
  endgenerate

  // ---------------- control ----------------
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_last_nxt  = out_last_r;
    out_sum_nxt   = out_sum_r;
    ctrl.ins      = 1'b0;
    ctrl.shift    = 1'b0;
    busy          = 1'b0;

    unique case (state_r)
      psds_pkg::ST_FILL: begin
        if (accept) begin
          if (!full) begin
            ctrl.ins = 1'b1;
            cnt_nxt  = cnt_r + psds_pkg::CNT_W'(1);
          end
          if (in_is_last) begin
            state_nxt = psds_pkg::ST_DRAIN;
          end
        end
      end
      psds_pkg::ST_DRAIN: begin
        busy          = 1'b1;
        ctrl.shift    = 1'b1;
        out_valid_nxt = 1'b1;
        out_sum_nxt   = links[0].value;
        out_last_nxt  = (cnt_r == psds_pkg::CNT_W'(1));
        cnt_nxt       = cnt_r - psds_pkg::CNT_W'(1);
        if (cnt_r == psds_pkg::CNT_W'(1)) begin
          state_nxt = psds_pkg::ST_FILL;
        end
      end
      default: begin
        state_nxt = psds_pkg::ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psds_pkg::ST_FILL;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sum_r <= out_sum_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sorted_sum = out_sum_r;
  assign out_last_out   = out_last_r && out_valid_r;

  // ---------------- assertions ----------------
  // occupied cells always match the fill count
  a_cnt_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(cnt_r))
    else $error("chain occupancy differs from fill count");

  // draining never runs on an empty chain
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psds_pkg::ST_DRAIN) |-> (cnt_r != '0))
    else $error("drain with empty chain");

  // a full chain ignores a new item
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && full) |=> (cnt_r == psds_pkg::CNT_W'(N)))
    else $error("item inserted into full chain");

  // head never holds a smaller sum than its neighbor
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    links[1].valid |-> ($signed(links[0].value) >= $signed(links[1].value)))
    else $error("chain head out of order");

endmodule
